// ----- design/aes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and functions for AES-128 CBC decryption
// Holds the register indexes, controller states, command/status structs and
// the byte-level transforms used by key expansion and the inverse rounds.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned WordWidth  = 64;
    localparam int unsigned BlockWidth = 128;
    localparam int unsigned NumRounds  = 10;
    localparam int unsigned RoundWidth = 4;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] REG_KEY_HI = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_LO = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_IV_HI  = 2'd2;
    localparam logic [CfgIdxWidth-1:0] REG_IV_LO  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_LAST,
        ST_OUT
    } aes_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  key_start;
        logic                  key_step;
        logic                  load;
        logic                  round;
        logic                  last;
        logic [RoundWidth-1:0] rnd;
    } aes_cmd_t;

    typedef struct packed {
        logic pending_key;
    } aes_status_t;

    // GF(2^8) multiply by x
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // GF(2^8) multiply, shift and add
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ x;
            x = xt(x);
        end
        gm = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = (x << n) | (x >> (8 - n));
    endfunction

    // Multiplicative inverse by a^254 via fixed chain
    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] p;
        logic [7:0] r;
        p = a;
        r = 8'h01;
        // 254 = 0b11111110
        for (int i = 1; i < 8; i++)
        begin
            p = gm(p, p);
            r = gm(r, p);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] v;
        v = ginv(a);
        sbox = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    endfunction

    // Constant forward table, built at elaboration
    typedef logic [7:0] byte_tab_t [256];

    function automatic byte_tab_t build_fwd();
        byte_tab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = sbox(8'(i));
        return t;
    endfunction

    function automatic byte_tab_t build_inv();
        byte_tab_t t;
        for (int i = 0; i < 256; i++)
            t[sbox(8'(i))] = 8'(i);
        return t;
    endfunction

    localparam byte_tab_t FWD_SBOX    = build_fwd();
    localparam byte_tab_t INV_SUB_TAB = build_inv();

    // Byte i of a block, byte 0 most significant
    function automatic logic [7:0] bget(input logic [BlockWidth-1:0] s, input int i);
        bget = s[BlockWidth-1-8*i -: 8];
    endfunction

    // Inverse ShiftRows then inverse SubBytes
    function automatic logic [BlockWidth-1:0] inv_rows_subs(input logic [BlockWidth-1:0] s);
        logic [BlockWidth-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[BlockWidth-1-8*(r+4*c) -: 8] = INV_SUB_TAB[bget(s, r + 4*((c + 4 - r) % 4))];
        return o;
    endfunction

    function automatic logic [BlockWidth-1:0] inv_mix(input logic [BlockWidth-1:0] s);
        logic [BlockWidth-1:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = bget(s, 4*c);
            a1 = bget(s, 4*c+1);
            a2 = bget(s, 4*c+2);
            a3 = bget(s, 4*c+3);
            o[BlockWidth-1-8*(4*c)   -: 8] = gm(a0,8'h0E)^gm(a1,8'h0B)^gm(a2,8'h0D)^gm(a3,8'h09);
            o[BlockWidth-1-8*(4*c+1) -: 8] = gm(a0,8'h09)^gm(a1,8'h0E)^gm(a2,8'h0B)^gm(a3,8'h0D);
            o[BlockWidth-1-8*(4*c+2) -: 8] = gm(a0,8'h0D)^gm(a1,8'h09)^gm(a2,8'h0E)^gm(a3,8'h0B);
            o[BlockWidth-1-8*(4*c+3) -: 8] = gm(a0,8'h0B)^gm(a1,8'h0D)^gm(a2,8'h09)^gm(a3,8'h0E);
        end
        return o;
    endfunction

    // One key expansion step: previous round key to next
    function automatic logic [BlockWidth-1:0] key_next(input logic [BlockWidth-1:0] k,
                                                       input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {FWD_SBOX[k[23:16]] ^ rc, FWD_SBOX[k[15:8]], FWD_SBOX[k[7:0]],
             FWD_SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- design/aes_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_stream_if: valid/ready channel with a generic payload
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface aes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/aes_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctrl: sequencing state machine
// Runs key expansion after key writes and the ten inverse rounds per block.
// ----------------------------------------------------------------------------
module aes_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_fire,
    input  aes_pkg::aes_status_t  status,
    output aes_pkg::aes_cmd_t     cmd,
    output logic                  in_ready,
    output logic                  out_valid
);

    aes_pkg::aes_state_t state_reg, state_next;
    logic [aes_pkg::RoundWidth-1:0] rnd_reg, rnd_next;

    // Hold state and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aes_pkg::ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.rnd    = rnd_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                if (status.pending_key)
                begin
                    cmd.key_start = 1'b1;
                    rnd_next      = 4'd1;
                    state_next    = aes_pkg::ST_EXPAND;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_fire)
                    begin
                        cmd.load   = 1'b1;
                        rnd_next   = 4'd9;
                        state_next = aes_pkg::ST_ROUND;
                    end
                end
            end
            aes_pkg::ST_EXPAND:
            begin
                cmd.key_step = 1'b1;
                rnd_next     = rnd_reg + 4'd1;
                if (rnd_reg == 4'(aes_pkg::NumRounds))
                    state_next = aes_pkg::ST_IDLE;
            end
            aes_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg - 4'd1;
                if (rnd_reg == 4'd1)
                    state_next = aes_pkg::ST_LAST;
            end
            aes_pkg::ST_LAST:
            begin
                cmd.last   = 1'b1;
                state_next = aes_pkg::ST_OUT;
            end
            aes_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = aes_pkg::ST_IDLE;
            end
            default:
                state_next = aes_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- design/aes_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_dp: datapath with round key store, state register and chain register
// One inverse round per cycle on a shared round unit; one key step per cycle.
// ----------------------------------------------------------------------------
module aes_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]     cfg_idx,
    input  logic [aes_pkg::WordWidth-1:0]       cfg_data,
    input  aes_pkg::aes_cmd_t                   cmd,
    output aes_pkg::aes_status_t                status,
    input  logic [aes_pkg::BlockWidth-1:0]      cipher,
    input  logic                                restart,
    output logic [aes_pkg::BlockWidth-1:0]      plain
);

    logic [aes_pkg::WordWidth-1:0] key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic                          pend_reg;
    logic [aes_pkg::BlockWidth-1:0] rk_mem [aes_pkg::NumRounds+1];
    logic [aes_pkg::BlockWidth-1:0] kexp_reg;
    logic [7:0]                     rc_reg;
    logic [aes_pkg::BlockWidth-1:0] st_reg, st_next;
    logic [aes_pkg::BlockWidth-1:0] chain_reg, prev_reg;
    logic [aes_pkg::BlockWidth-1:0] kn, rk, subs;

    // Hold configuration registers and pending key flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            iv_hi_reg  <= '0;
            iv_lo_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.key_start)
                pend_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    aes_pkg::REG_KEY_HI: begin key_hi_reg <= cfg_data; pend_reg <= 1'b1; end
                    aes_pkg::REG_KEY_LO: begin key_lo_reg <= cfg_data; pend_reg <= 1'b1; end
                    aes_pkg::REG_IV_HI:  iv_hi_reg <= cfg_data;
                    aes_pkg::REG_IV_LO:  iv_lo_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign status.pending_key = pend_reg;

    // Expand round keys, one per cycle
    assign kn = aes_pkg::key_next(kexp_reg, rc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.key_start)
        begin
            kexp_reg  <= {key_hi_reg, key_lo_reg};
            rc_reg    <= 8'h01;
            rk_mem[0] <= {key_hi_reg, key_lo_reg};
        end
        else if (cmd.key_step)
        begin
            kexp_reg        <= kn;
            rc_reg          <= aes_pkg::xt(rc_reg);
            rk_mem[cmd.rnd] <= kn;
        end
    end

    // Shared inverse round unit
    assign rk   = rk_mem[cmd.last ? 4'd0 : cmd.rnd];
    assign subs = aes_pkg::inv_rows_subs(st_reg);

    always_comb
    begin
        st_next = st_reg;
        if (cmd.load)
            st_next = cipher ^ rk_mem[aes_pkg::NumRounds];
        else if (cmd.round)
            st_next = aes_pkg::inv_mix(subs ^ rk);
        else if (cmd.last)
            st_next = (subs ^ rk) ^ prev_reg;
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    // Advance chain value on each accepted block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.load)
        begin
            prev_reg  <= restart ? {iv_hi_reg, iv_lo_reg} : chain_reg;
            chain_reg <= cipher;
        end
    end

    assign plain = st_reg;

endmodule

// ----- design/aes128_cbc_decrypt_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_top: AES-128 CBC decryption, one block at a time
// Controller sequences a shared inverse round unit and key expansion.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_hi/key_lo/iv_hi/iv_lo through the cfg port while idle. A key
//   write queues expansion: eleven round keys are built before the
//   next block is taken.
//   in_ch carries cipher_hi, cipher_lo and restart; restart chains from IV.
//   out_ch carries plain_hi and plain_lo.
//   Sequence per block: accept, nine shared rounds, one final round, then
//   the result is presented; the single round unit iterates all ten rounds.
//   One block is in flight; in_ch.ready stays low until the result beat is
//   taken, so a stalled receiver holds the result and blocks input.
//   Reset clears configuration, chain value and controller; the round key
//   store holds nothing until the first key write.
// ----------------------------------------------------------------------------
module aes128_cbc_decrypt_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]   cfg_idx,
    input  logic [aes_pkg::WordWidth-1:0]     cfg_data,
    aes_stream_if.sink                        in_ch,
    aes_stream_if.source                      out_ch
);

    aes_pkg::aes_cmd_t    cmd;
    aes_pkg::aes_status_t status;
    logic                 in_ready, out_valid;
    logic [aes_pkg::BlockWidth-1:0] plain;

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data.plain_hi = plain[127:64];
    assign out_ch.data.plain_lo = plain[63:0];

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_ch.valid && in_ready),
        .out_fire  (out_valid && out_ch.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    aes_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .cipher   ({in_ch.data.cipher_hi, in_ch.data.cipher_lo}),
        .restart  (in_ch.data.restart),
        .plain    (plain)
    );

`ifndef SYNTH
    // No input beat while a result waits
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    // Result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ch.ready |=> out_valid && $stable(plain))
        else $error("result changed under stall");
    // Load leads into rounds
    a_load_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.round && cmd.rnd == 4'd9) else $error("round sequence broken");
`endif

endmodule
